// ----- sv/salfu_pkg.sv -----
// Package for the set-associative LFU cache: sizes, way and row types and the
// set-index function shared by the top level and the lookup logic.
// No dependencies.
`default_nettype none

package salfu_pkg;

   localparam int NUM_SETS = 16;
   localparam int NUM_WAYS = 4;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 16;
   localparam int MISS_W  = 32;
   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   localparam int REQ_W = 8 * ((ADDR_W + 7) / 8);
   localparam int RSP_W = 8 * ((1 + MISS_W + 7) / 8);
   localparam int RSP_PAD_W = RSP_W - 1 - MISS_W;

   localparam logic [COUNT_W-1:0] USE_MAX  = '1;
   localparam logic [MISS_W-1:0]  MISS_MAX = '1;

   // Residues of the byte weights, used to fold the address before the
   // reciprocal step of the set-index computation.
   localparam int  FOLD_W = 20;
   localparam longint RES8  = (64'd1 << 8) % NUM_SETS;
   localparam longint RES16 = (64'd1 << 16) % NUM_SETS;
   localparam longint RES24 = (64'd1 << 24) % NUM_SETS;
   localparam int  RECIP_SHIFT = FOLD_W + $clog2(NUM_SETS);
   localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + NUM_SETS - 1) / NUM_SETS;
   localparam int  PROD_W = 2 * FOLD_W + 2;

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  tag;
      logic [COUNT_W-1:0] count;
   } way_type;

   typedef way_type [NUM_WAYS-1:0] row_type;

   typedef struct packed {
      logic                hit;
      logic [NUM_WAYS-1:0] hit_vec;
      row_type             row;
   } lookup_type;

   // The address modulo NUM_SETS: the bytes are folded with their residues
   // into a value below 2**FOLD_W, and a multiply by the rounded-up
   // reciprocal gives the exact quotient of that value.
   function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr);
      logic [FOLD_W-1:0] folded;
      logic [PROD_W-1:0] prod;
      logic [FOLD_W-1:0] quot;
      logic [FOLD_W-1:0] rem;
      folded = FOLD_W'(addr[7:0])
             + FOLD_W'(FOLD_W'(addr[15:8]) * FOLD_W'(RES8))
             + FOLD_W'(FOLD_W'(addr[23:16]) * FOLD_W'(RES16))
             + FOLD_W'(FOLD_W'(addr[31:24]) * FOLD_W'(RES24));
      prod = PROD_W'(folded) * PROD_W'(RECIP);
      quot = FOLD_W'(prod >> RECIP_SHIFT);
      rem  = folded - FOLD_W'(quot * FOLD_W'(NUM_SETS));
      return SET_W'(rem);
   endfunction

endpackage

`default_nettype wire

// ----- sv/salfu_lookup.sv -----
// Tag compare, victim choice and row update for one set of the LFU cache.
// Depends on salfu_pkg for the row and lookup types.
`default_nettype none

module salfu_lookup
   import salfu_pkg::*;
(
   input  wire logic [ADDR_W-1:0] addr,
   input  wire row_type           row,
   output lookup_type             result
);

   logic [NUM_WAYS-1:0] hit_vec;
   logic [NUM_WAYS-1:0] empty_vec;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    empty_way;
   logic [WAY_W-1:0]    min_way;
   logic [WAY_W-1:0]    victim;
   logic [COUNT_W-1:0]  best_count;
   row_type             row_new;

   always_comb begin
      hit_vec   = '0;
      empty_vec = '0;
      hit_way   = '0;
      empty_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         hit_vec[w]   = row[w].valid && (row[w].tag == addr);
         empty_vec[w] = !row[w].valid;
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec[w]) begin
            empty_way = WAY_W'(w);
         end
      end
   end

   // Lowest count in a full set, the lower way winning ties.
   always_comb begin
      best_count = row[0].count;
      min_way    = '0;
      for (int w = 1; w < NUM_WAYS; w++) begin
         if (row[w].count < best_count) begin
            best_count = row[w].count;
            min_way    = WAY_W'(w);
         end
      end
   end

   assign victim = (|empty_vec) ? empty_way : min_way;

   always_comb begin
      row_new = row;
      if (|hit_vec) begin
         if (row[hit_way].count != USE_MAX) begin
            row_new[hit_way].count = row[hit_way].count + COUNT_W'(1);
         end
      end else begin
         row_new[victim].valid = 1'b1;
         row_new[victim].tag   = addr;
         row_new[victim].count = COUNT_W'(1);
      end
   end

   assign result.hit     = |hit_vec;
   assign result.hit_vec = hit_vec;
   assign result.row     = row_new;

endmodule

`default_nettype wire

// ----- sv/set_assoc_lfu_cache_sim.sv -----
// Top level of the set-associative LFU cache: set memory, lookup stage,
// result register and miss counter.
// Depends on salfu_pkg and salfu_lookup.
//
//   channel | direction | fields (tdata, lowest bit first)
//   req     | in        | access_address[31:0]
//   rsp     | out       | hit, miss_total[31:0], 7 zero bits
//
// One item enters per cycle while rsp does not stall; rsp_tvalid rises after the item
// has passed the registered read of the set memory and then the result register.
// After reset a clearing pass writes every set once, and
// req_tready stays low until it is done.
// A stalled rsp channel holds the lookup stage, and req_tready drops with it.
// A back-to-back access to the same set takes the row just written from a bypass register.
`default_nettype none

module set_assoc_lfu_cache_sim
   import salfu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // access_address
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [RSP_W-1:0] rsp_tdata    // hit, miss_total, zero fill
);

   row_type mem [NUM_SETS];

   logic              clear_busy_ff, clear_busy_in;
   logic [SET_W-1:0]  clear_idx_ff, clear_idx_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic [MISS_W-1:0] miss_ff, miss_in;

   logic [ADDR_W-1:0] addr_ff;
   logic [SET_W-1:0]  set_ff;
   row_type           rd_row_ff;
   row_type           fwd_row_ff;
   logic [SET_W-1:0]  fwd_set_ff;
   logic              rsp_hit_ff;
   logic [MISS_W-1:0] rsp_miss_ff;

   logic              req_accept;
   logic              out_free;
   logic              adv;
   logic [SET_W-1:0]  req_set;
   row_type           cur_row;
   lookup_type        lk;

   assign req_set    = set_of(req_tdata[ADDR_W-1:0]);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = s1_valid_ff && out_free;
   assign req_tready = !clear_busy_ff && (!s1_valid_ff || out_free);
   assign req_accept = req_tvalid && req_tready;

   assign cur_row = (fwd_valid_ff && (fwd_set_ff == set_ff)) ? fwd_row_ff : rd_row_ff;

   salfu_lookup u_lookup (
      .addr   (addr_ff),
      .row    (cur_row),
      .result (lk)
   );

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_idx_in  = clear_idx_ff;
      if (clear_busy_ff) begin
         if (clear_idx_ff == SET_W'(NUM_SETS - 1)) begin
            clear_busy_in = 1'b0;
         end else begin
            clear_idx_in = clear_idx_ff + SET_W'(1);
         end
      end

      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff || adv;

      miss_in = miss_ff;
      if (!lk.hit && (miss_ff != MISS_MAX)) begin
         miss_in = miss_ff + MISS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         miss_ff       <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         if (adv) begin
            miss_ff <= miss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff   <= req_tdata[ADDR_W-1:0];
         set_ff    <= req_set;
         rd_row_ff <= mem[req_set];
      end
      if (adv) begin
         fwd_row_ff  <= lk.row;
         fwd_set_ff  <= set_ff;
         rsp_hit_ff  <= lk.hit;
         rsp_miss_ff <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_idx_ff] <= '0;
      end else if (adv) begin
         mem[set_ff] <= lk.row;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_miss_ff, rsp_hit_ff};

   a_hit_way_unique: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(lk.hit_vec))
      else $error("more than one way matched the address");

   a_hit_keeps_misses: assert property (@(posedge clock) disable iff (reset)
      (adv && lk.hit) |=> (miss_ff == $past(miss_ff)))
      else $error("miss counter changed on a hit");

   a_miss_counts: assert property (@(posedge clock) disable iff (reset)
      (adv && !lk.hit && (miss_ff != MISS_MAX))
         |=> (miss_ff == MISS_W'($past(miss_ff) + MISS_W'(1))))
      else $error("miss counter did not advance on a miss");

   a_clear_empty_pipe: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (!s1_valid_ff && !rsp_valid_ff && !fwd_valid_ff))
      else $error("item in flight during the clearing pass");

endmodule

`default_nettype wire

// ----- dv/tb_set_assoc_lfu_cache_sim.sv -----
// Testbench for set_assoc_lfu_cache_sim: drives access addresses and checks the hit flag and
// miss total against a predictor of the set-associative LFU replacement.
// Depends on salfu_pkg and the set_assoc_lfu_cache_sim RTL.
`timescale 1ns / 100ps

module tb_set_assoc_lfu_cache_sim;
   import salfu_pkg::*;

   localparam int LINES     = NUM_SETS * NUM_WAYS;
   localparam int HOLD_AT   = 500;
   localparam int HOLD_LEN  = 400;
   localparam int CALM_TAIL = 200;
   localparam int HOT_HITS  = 60;

   typedef struct {
      bit [ADDR_W-1:0] addr;
      bit              drain_first;
      bit              calm;
   } access_item_type;

   typedef struct {
      bit              hit;
      bit [MISS_W-1:0] miss_total;
   } cache_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // access_address
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // hit, miss_total, zero fill

   access_item_type  access_q[$];
   cache_result_type expected_q[$];

   bit                line_valid [LINES];
   bit [ADDR_W-1:0]   line_tag   [LINES];
   bit [COUNT_W-1:0]  line_uses  [LINES];
   bit [MISS_W-1:0]   miss_count;

   int unsigned sent_count = 0;
   int unsigned err_count  = 0;
   int unsigned send_gap   = 0;
   int unsigned recv_gap   = 0;
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   bit          quiet_phase = 1'b0;

   set_assoc_lfu_cache_sim u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic cache_result_type predict_access(input bit [ADDR_W-1:0] addr);
      int               base;
      int               victim;
      bit               have_empty;
      bit               have_min;
      bit [COUNT_W-1:0] min_uses;
      cache_result_type res;
      base       = int'(addr % ADDR_W'(NUM_SETS)) * NUM_WAYS;
      victim     = 0;
      have_empty = 1'b0;
      have_min   = 1'b0;
      min_uses   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (line_valid[base + w] && line_tag[base + w] == addr) begin
            if (line_uses[base + w] != USE_MAX)
               line_uses[base + w] = line_uses[base + w] + 1'b1;
            res.hit        = 1'b1;
            res.miss_total = miss_count;
            return res;
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!line_valid[base + w]) begin
            if (!have_empty) begin
               have_empty = 1'b1;
               victim     = w;
            end
         end else if (!have_empty && (!have_min || line_uses[base + w] < min_uses)) begin
            have_min = 1'b1;
            min_uses = line_uses[base + w];
            victim   = w;
         end
      end
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = addr;
      line_uses[base + victim]  = COUNT_W'(1);
      if (miss_count != MISS_MAX)
         miss_count = miss_count + 1'b1;
      res.hit        = 1'b0;
      res.miss_total = miss_count;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      err_count++;
   endtask

   task automatic queue_access(input bit [ADDR_W-1:0] addr, input bit drain_first = 1'b0,
                               input bit calm = 1'b0);
      access_item_type item;
      item.addr        = addr;
      item.drain_first = drain_first;
      item.calm        = calm;
      access_q.insert(access_q.size(), item);
   endtask

   // Most accesses come from a small pool spread over the sets, skewed so that use
   // counts differ; the rest are fully random addresses.
   task automatic queue_random(input int count, input int calm_from);
      bit [ADDR_W-1:0] pool [96];
      bit [ADDR_W-1:0] addr;
      foreach (pool[i]) pool[i] = $urandom;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            addr = $urandom;
         else
            addr = pool[$urandom_range(0, $urandom_range(0, 95))];
         queue_access(addr, 1'b0, i >= calm_from);
      end
   endtask

   initial begin
      queue_access(32'h0000_0000);
      repeat (3) queue_access(32'h0000_0000);
      for (int w = 1; w < NUM_WAYS; w++) queue_access(ADDR_W'(w * NUM_SETS));
      for (int w = 1; w < NUM_WAYS; w++) queue_access(ADDR_W'(w * NUM_SETS));
      queue_access(ADDR_W'(NUM_WAYS * NUM_SETS));
      queue_access(32'hFFFF_FFF0);
      queue_access(32'h0000_0000);
      for (int w = 0; w <= NUM_WAYS; w++) queue_access(ADDR_W'(1 + w * NUM_SETS));
      queue_access(32'hFFFF_FFFF);
      queue_access(32'hFFFF_FFFF);
      queue_access(32'h0000_0001);

      queue_random(900, 900);
      access_q[access_q.size() - 300].drain_first = 1'b1;

      // Hit one entry many times, then make sure it survives replacement in its
      // full set.
      queue_access(32'h0000_0002, 1'b1, 1'b1);
      for (int i = 0; i < HOT_HITS; i++) queue_access(32'h0000_0002, 1'b0, 1'b1);
      for (int w = 1; w <= NUM_WAYS; w++) queue_access(ADDR_W'(2 + w * NUM_SETS), 1'b0, 1'b1);
      queue_access(32'h0000_0002, 1'b0, 1'b1);

      queue_random(900, 900 - CALM_TAIL);

      @(negedge reset);
      while (access_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= '0;
         send_gap    <= 0;
         quiet_phase <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.insert(expected_q.size(), predict_access(access_q[0].addr));
            access_q.pop_front();
            sent_count <= sent_count + 1;
         end
         quiet_phase <= (access_q.size() == 0) || access_q[0].calm;
         if (req_tvalid && !req_tready) begin
            // Item still on offer; hold it.
         end else if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (access_q.size() != 0 &&
                      !(access_q[0].drain_first && expected_q.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'(access_q[0].addr);
            if (!access_q[0].calm && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 12);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The receiver stops for a long stretch once, while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count == HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cache_result_type want;
      bit               got_hit;
      bit [MISS_W-1:0]  got_miss;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_hit  = rsp_tdata[0];
            got_miss = rsp_tdata[MISS_W:1];
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result item", rsp_tdata, 0);
            end else begin
               want = expected_q.pop_front();
               if (got_hit !== want.hit)
                  report_mismatch("hit", got_hit, want.hit);
               if (got_miss !== want.miss_total)
                  report_mismatch("miss_total", got_miss, want.miss_total);
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            recv_gap   <= $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

endmodule
